// ===== rtl/bfb_pkg.sv =====
// Shared types and constants of the bit field buffer.
package bfb_pkg;

  localparam int BUFFER_BYTES_DEF = 1024;
  localparam int MAX_FIELD_BITS_DEF = 64;

  localparam int START_W = 13;
  localparam int COUNT_W = 7;
  localparam int VALUE_W = 64;
  localparam int BYTE_W = 8;

  localparam logic CMD_PACK = 1'b0;
  localparam logic CMD_UNPACK = 1'b1;

  localparam logic [BYTE_W-1:0] BYTE_ONES = 8'hFF;
  localparam logic [2:0] BIT_FIRST = 3'd0;
  localparam logic [2:0] BIT_LAST = 3'd7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_e;

  // Per-cycle control from the sequencer to the byte lane.
  typedef struct packed {
    logic       load;
    logic       step;
    logic       pack;
    logic [2:0] first_bit;
    logic [2:0] last_bit;
  } ctl_t;

endpackage

// ===== rtl/bfb_if.sv =====
// Request and response channel interfaces of the bit field buffer.
interface bfb_req_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [bfb_pkg::START_W-1:0] bit_start;
  logic [bfb_pkg::COUNT_W-1:0] bit_count;
  logic [bfb_pkg::VALUE_W-1:0] write_value;

  modport source (output valid, cmd, bit_start, bit_count, write_value, input ready);
  modport sink (input valid, cmd, bit_start, bit_count, write_value, output ready);
endinterface

interface bfb_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [bfb_pkg::VALUE_W-1:0] read_value;
  logic                        range_error;

  modport source (output valid, read_value, range_error, input ready);
  modport sink (input valid, read_value, range_error, output ready);
endinterface

// ===== rtl/bfb_store.sv =====
// Byte store with one registered read port and one write port.
module bfb_store #(
  parameter int BUFFER_BYTES = bfb_pkg::BUFFER_BYTES_DEF,
  localparam int AddrW = $clog2(BUFFER_BYTES)
) (
  input  logic                       clk_i,
  input  logic                       rd_en_i,
  input  logic [AddrW-1:0]           rd_addr_i,
  output logic [bfb_pkg::BYTE_W-1:0] rd_data_o,
  input  logic                       wr_en_i,
  input  logic [AddrW-1:0]           wr_addr_i,
  input  logic [bfb_pkg::BYTE_W-1:0] wr_data_i
);

  logic [bfb_pkg::BYTE_W-1:0] mem_q [BUFFER_BYTES];
  logic [bfb_pkg::BYTE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/bfb_lane.sv =====
// Byte lane: field shift registers and the read-modify-write merge of one byte.
module bfb_lane #(
  parameter int MAX_FIELD_BITS = bfb_pkg::MAX_FIELD_BITS_DEF
) (
  input  logic                        clk_i,
  input  bfb_pkg::ctl_t               ctl_i,
  input  logic [bfb_pkg::VALUE_W-1:0] write_value_i,
  input  logic [bfb_pkg::BYTE_W-1:0]  rd_data_i,
  output logic [bfb_pkg::BYTE_W-1:0]  wr_data_o,
  output logic [bfb_pkg::VALUE_W-1:0] read_value_o
);

  logic [MAX_FIELD_BITS-1:0]  val_q;
  logic [MAX_FIELD_BITS-1:0]  acc_q;
  logic [bfb_pkg::BYTE_W-1:0] mask;
  logic [bfb_pkg::BYTE_W-1:0] put_bits;
  logic [bfb_pkg::BYTE_W-1:0] got_bits;
  logic [2:0]                 align;
  logic [3:0]                 nbits;

  // Bits first_bit..last_bit of the byte (counted from its MSB) belong to the field.
  always_comb begin
    align = bfb_pkg::BIT_LAST - ctl_i.last_bit;
    nbits = {1'b0, ctl_i.last_bit} - {1'b0, ctl_i.first_bit} + 4'd1;
    mask = (bfb_pkg::BYTE_ONES >> ctl_i.first_bit) & (bfb_pkg::BYTE_ONES << align);
    put_bits = val_q[bfb_pkg::BYTE_W-1:0] << align;
    got_bits = (rd_data_i & mask) >> align;
    wr_data_o = (rd_data_i & ~mask) | (put_bits & mask);
  end

  // Packing walks the field from its last byte, consuming value bits from the bottom;
  // unpacking walks from the first byte and shifts bits in at the bottom.
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      val_q <= write_value_i[MAX_FIELD_BITS-1:0];
      acc_q <= '0;
    end else if (ctl_i.step) begin
      if (ctl_i.pack) begin
        val_q <= val_q >> nbits;
      end else begin
        acc_q <= (acc_q << nbits) | MAX_FIELD_BITS'(got_bits);
      end
    end
  end

  assign read_value_o = bfb_pkg::VALUE_W'(acc_q);

endmodule

// ===== rtl/bfb_seq.sv =====
// Sequencer: range check and the walk over the bytes that a field spans.
module bfb_seq #(
  parameter int BUFFER_BYTES = bfb_pkg::BUFFER_BYTES_DEF,
  parameter int MAX_FIELD_BITS = bfb_pkg::MAX_FIELD_BITS_DEF,
  localparam int AddrW = $clog2(BUFFER_BYTES)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        cmd_i,
  input  logic [bfb_pkg::START_W-1:0] bit_start_i,
  input  logic [bfb_pkg::COUNT_W-1:0] bit_count_i,
  input  logic                        out_free_i,
  output logic                        in_ready_o,
  output bfb_pkg::ctl_t               ctl_o,
  output logic                        rd_en_o,
  output logic [AddrW-1:0]            rd_addr_o,
  output logic                        wr_en_o,
  output logic [AddrW-1:0]            wr_addr_o,
  output logic                        finish_o,
  output logic                        err_o
);

  localparam int LimW = AddrW + 4;
  localparam int SumW = (LimW > bfb_pkg::START_W + 1) ? LimW : bfb_pkg::START_W + 1;
  localparam logic [SumW-1:0] BitLimit = SumW'(BUFFER_BYTES * 8);
  localparam logic [bfb_pkg::COUNT_W-1:0] MaxCount = bfb_pkg::COUNT_W'(MAX_FIELD_BITS);

  bfb_pkg::state_e state_q, state_d;

  logic             accept;
  logic             issuing;
  logic [SumW-1:0]  start_ext;
  logic [SumW-1:0]  end_sum;
  logic [SumW-1:0]  end_pos;
  logic             err_in;
  logic             empty_in;

  logic             cmd_q;
  logic             err_q;
  logic             skip_q;
  logic [AddrW-1:0] first_addr_q;
  logic [AddrW-1:0] last_addr_q;
  logic [2:0]       first_bit_q;
  logic [2:0]       last_bit_q;
  logic [AddrW-1:0] cur_q;
  logic             issue_done_q;
  logic             cur_first;
  logic             cur_last;
  logic             cur_stop;

  logic             s2_valid_q;
  logic [AddrW-1:0] s2_addr_q;
  logic [2:0]       s2_first_q;
  logic [2:0]       s2_last_bit_q;
  logic             s2_end_q;

  always_comb begin
    start_ext = SumW'(bit_start_i);
    end_sum = start_ext + SumW'(bit_count_i);
    end_pos = end_sum - SumW'(1);
    err_in = (bit_count_i > MaxCount) || (end_sum > BitLimit);
    empty_in = (bit_count_i == '0);
  end

  assign accept = in_valid_i && in_ready_o;
  assign issuing = (state_q == bfb_pkg::ST_RUN) && !issue_done_q;
  assign cur_first = (cur_q == first_addr_q);
  assign cur_last = (cur_q == last_addr_q);
  assign cur_stop = (cmd_q == bfb_pkg::CMD_PACK) ? cur_first : cur_last;

  always_comb begin
    state_d = state_q;
    case (state_q)
      bfb_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = (err_in || empty_in) ? bfb_pkg::ST_FINISH : bfb_pkg::ST_RUN;
        end
      end
      bfb_pkg::ST_RUN: begin
        if (s2_valid_q && s2_end_q) begin
          state_d = bfb_pkg::ST_FINISH;
        end
      end
      bfb_pkg::ST_FINISH: begin
        if (out_free_i) begin
          state_d = bfb_pkg::ST_IDLE;
        end
      end
      default: state_d = bfb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == bfb_pkg::ST_IDLE);
    finish_o = (state_q == bfb_pkg::ST_FINISH) && out_free_i;
    err_o = err_q && !skip_q;
    rd_en_o = issuing;
    rd_addr_o = cur_q;
    wr_en_o = s2_valid_q && (cmd_q == bfb_pkg::CMD_PACK);
    wr_addr_o = s2_addr_q;
    ctl_o.load = accept;
    ctl_o.step = s2_valid_q;
    ctl_o.pack = (cmd_q == bfb_pkg::CMD_PACK);
    ctl_o.first_bit = s2_first_q;
    ctl_o.last_bit = s2_last_bit_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfb_pkg::ST_IDLE;
      issue_done_q <= 1'b1;
      s2_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      s2_valid_q <= issuing;
      if (accept) begin
        issue_done_q <= 1'b0;
      end else if (issuing && cur_stop) begin
        issue_done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
      err_q <= err_in;
      skip_q <= 1'b0;
      first_addr_q <= AddrW'(start_ext >> 3);
      last_addr_q <= AddrW'(end_pos >> 3);
      first_bit_q <= bit_start_i[2:0];
      last_bit_q <= end_pos[2:0];
      cur_q <= (cmd_i == bfb_pkg::CMD_PACK) ? AddrW'(end_pos >> 3) : AddrW'(start_ext >> 3);
    end else if (issuing && !cur_stop) begin
      cur_q <= (cmd_q == bfb_pkg::CMD_PACK) ? cur_q - AddrW'(1) : cur_q + AddrW'(1);
    end
    if (issuing) begin
      s2_addr_q <= cur_q;
      s2_first_q <= cur_first ? first_bit_q : bfb_pkg::BIT_FIRST;
      s2_last_bit_q <= cur_last ? last_bit_q : bfb_pkg::BIT_LAST;
      s2_end_q <= cur_stop;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> state_q == bfb_pkg::ST_RUN)
    else $error("byte in flight outside of a field walk");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> s2_first_q <= s2_last_bit_q)
    else $error("empty bit span inside a byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bfb_pkg::ST_RUN |-> !err_q)
    else $error("rejected field reached the store");

endmodule

// ===== rtl/bit_field_buffer_pack_unpack.sv =====
// Top level of the bit-addressed field buffer with MSB-first byte order.
//
// This block keeps a store of BUFFER_BYTES bytes that is addressed by bit, where bit 0 is
// the most significant bit of byte 0. A pack beat (cmd 0) writes the low bit_count bits of
// write_value so that the field's most significant bit lands at bit_start, and leaves every
// other bit untouched. An unpack beat (cmd 1) returns the field zero-extended in read_value.
// Each request beat yields exactly one response beat. A field longer than MAX_FIELD_BITS or
// one that runs past the end of the store is rejected: range_error is set, read_value is
// zero and the store does not change. A zero-length field returns zero without error. The
// store comes out of reset with undefined contents and needs no clearing pass, so bits must
// be packed before they are unpacked. The walk moves one byte per cycle through the store's
// single read port and single write port, reading a byte and writing the merged byte back
// in the next cycle. A field spans 1 to 9 bytes, 8 or 9 for a 64-bit field; rejected and
// empty requests skip the walk. A finished response sits in its own output register, so a
// new request can be accepted while the previous response still waits for the sink.
module bit_field_buffer_pack_unpack #(
  parameter int BUFFER_BYTES = bfb_pkg::BUFFER_BYTES_DEF,
  parameter int MAX_FIELD_BITS = bfb_pkg::MAX_FIELD_BITS_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  bfb_req_if.sink   req_i,
  bfb_rsp_if.source rsp_o
);

  localparam int AddrW = $clog2(BUFFER_BYTES);

  bfb_pkg::ctl_t               ctl;
  logic                        out_free;
  logic                        finish;
  logic                        err;
  logic                        rd_en;
  logic [AddrW-1:0]            rd_addr;
  logic [bfb_pkg::BYTE_W-1:0]  rd_data;
  logic                        wr_en;
  logic [AddrW-1:0]            wr_addr;
  logic [bfb_pkg::BYTE_W-1:0]  wr_data;
  logic [bfb_pkg::VALUE_W-1:0] lane_value;

  logic                        out_valid_q;
  logic [bfb_pkg::VALUE_W-1:0] out_value_q;
  logic                        out_err_q;

  // The output register can take a new response when it is empty or being drained.
  assign out_free = !out_valid_q || rsp_o.ready;

  bfb_seq #(
    .BUFFER_BYTES  (BUFFER_BYTES),
    .MAX_FIELD_BITS(MAX_FIELD_BITS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .cmd_i      (req_i.cmd),
    .bit_start_i(req_i.bit_start),
    .bit_count_i(req_i.bit_count),
    .out_free_i (out_free),
    .in_ready_o (req_i.ready),
    .ctl_o      (ctl),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .finish_o   (finish),
    .err_o      (err)
  );

  bfb_store #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_store (
    .clk_i    (clk_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

  bfb_lane #(
    .MAX_FIELD_BITS(MAX_FIELD_BITS)
  ) u_lane (
    .clk_i        (clk_i),
    .ctl_i        (ctl),
    .write_value_i(req_i.write_value),
    .rd_data_i    (rd_data),
    .wr_data_o    (wr_data),
    .read_value_o (lane_value)
  );

  // Response valid: set when a result is loaded, cleared when the sink takes the beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // The accumulator stays zero for packs and rejected requests, so it can be copied as is.
  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_value_q <= lane_value;
      out_err_q <= err;
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.read_value = out_value_q;
  assign rsp_o.range_error = out_err_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.range_error) |-> rsp_o.read_value == '0)
    else $error("rejected request returned a nonzero value");

endmodule
